FILE: src/clns_pkg.sv
`timescale 1ns / 1ps
package clns_pkg;

    localparam int COLUMNS_DEF     = 20;
    localparam int ROWS_DEF        = 4;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam int ROW_W   = 2;
    localparam int ADDR_W  = 7;
    localparam int CFG_W   = 2;
    localparam int STEP_W  = 4;
    localparam int WB_W    = 15;
    localparam int WA_W    = 13;

    localparam logic [1:0] OP_INIT  = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_SETCUR = 2'd2;
    localparam logic [1:0] OP_WRITE = 2'd3;

    localparam logic [CFG_W-1:0] CFG_ROW0 = 2'd0;
    localparam logic [CFG_W-1:0] CFG_ROW1 = 2'd1;
    localparam logic [CFG_W-1:0] CFG_ROW2 = 2'd2;
    localparam logic [CFG_W-1:0] CFG_ROW3 = 2'd3;

    localparam logic [ADDR_W-1:0] ROW0_RST = 7'h00;
    localparam logic [ADDR_W-1:0] ROW1_RST = 7'h40;
    localparam logic [ADDR_W-1:0] ROW2_RST = 7'h14;
    localparam logic [ADDR_W-1:0] ROW3_RST = 7'h54;

    // command kinds handed from front to back
    localparam logic [1:0] K_INIT      = 2'd0;
    localparam logic [1:0] K_CMD       = 2'd1;
    localparam logic [1:0] K_DATA      = 2'd2;
    localparam logic [1:0] K_DATA_ADDR = 2'd3;

    localparam logic [7:0] CMD_CLEAR    = 8'h01;
    localparam logic [7:0] CMD_HOME     = 8'h02;
    localparam logic [7:0] CMD_SET_ADDR = 8'h80;

    localparam logic [WB_W-1:0] WAIT_POWERUP = 15'd20000;
    localparam logic [WA_W-1:0] WAIT_INIT0   = 13'd6050;
    localparam logic [WA_W-1:0] WAIT_INIT1   = 13'd210;
    localparam logic [WA_W-1:0] WAIT_SHORT   = 13'd50;
    localparam logic [WA_W-1:0] WAIT_STD     = 13'd100;
    localparam logic [WA_W-1:0] WAIT_LONG    = 13'd2050;

    localparam logic [STEP_W-1:0] INIT_LAST_STEP = 4'd13;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] byte_a;
        logic [7:0] byte_b;
    } t_cmd;

    typedef struct packed {
        logic            rs;
        logic [3:0]      nib;
        logic [WB_W-1:0] lead;
        logic [WA_W-1:0] after;
        logic            last;
    } t_xfer;

    function automatic t_xfer init_xfer(input logic [STEP_W-1:0] step);
        t_xfer x;
        x.rs     = 1'b0;
        x.lead   = '0;
        x.after  = WAIT_STD;
        x.last   = 1'b0;
        x.nib    = 4'h0;
        case (step)
            4'd0: begin
                x.nib = 4'h3; x.lead = WAIT_POWERUP; x.after = WAIT_INIT0;
            end
            4'd1: begin
                x.nib = 4'h3; x.after = WAIT_INIT1;
            end
            4'd2: begin
                x.nib = 4'h3; x.after = WAIT_SHORT;
            end
            4'd3: begin
                x.nib = 4'h2; x.after = WAIT_SHORT;
            end
            4'd4:  x.nib = 4'h2;
            4'd5:  x.nib = 4'h8;
            4'd6:  x.nib = 4'h0;
            4'd7:  x.nib = 4'h8;
            4'd8:  x.nib = 4'h0;
            4'd9: begin
                x.nib = 4'h1; x.after = WAIT_LONG;
            end
            4'd10: x.nib = 4'h0;
            4'd11: x.nib = 4'h6;
            4'd12: x.nib = 4'h0;
            4'd13: begin
                x.nib = 4'hF; x.last = 1'b1;
            end
            default: x.nib = 4'h0;
        endcase
        return x;
    endfunction

endpackage

FILE: src/char_lcd_nibble_sequencer.sv
`timescale 1ns / 1ps
// Character LCD nibble sequencer, 4-bit bus.
// Command channel: i_in_valid / o_in_stall with operation, target row and
// column, and character. A transaction is taken when valid is high and
// stall is low. Each command expands into nibble transfers on the output
// channel (o_out_valid / i_out_stall): reg select, nibble, wait before,
// wait after, and last on the final nibble of the command.
// Config channel: i_cfg_valid / o_cfg_ready, index 0..3 selects the base
// address of rows 1..4. Ready is always high; write only while idle.
// Throughput: one nibble per cycle at the output register unless stalled.
// A clear or set cursor is 2 nibbles, a write 2 or 4 (4 on a row wrap),
// init 14; the count is set by the nibble step counter in the back end.
// A taken command is written into the queue, and its first nibble is then
// loaded into the output register when that register is free.
// The front end keeps taking commands into a short queue while the back
// end is stalled; o_in_stall rises only when the queue is full. A stalled
// output holds its nibble. Reset empties the queue, drops output valid,
// homes the tracked cursor and restores the default row addresses.
module char_lcd_nibble_sequencer
    import clns_pkg::*;
#(
    parameter int COLUMNS     = COLUMNS_DEF,
    parameter int ROWS        = ROWS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [1:0]        i_operation,
    input  logic [7:0]        i_target_row,
    input  logic [7:0]        i_target_column,
    input  logic [7:0]        i_character,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CFG_W-1:0]  i_cfg_index,
    input  logic [ADDR_W-1:0] i_cfg_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic              o_reg_select,
    output logic [3:0]        o_nibble,
    output logic [WB_W-1:0]   o_wait_before_us,
    output logic [WA_W-1:0]   o_wait_after_us,
    output logic              o_last
);

    t_cmd  front_cmd, q_cmd;
    t_xfer xfer;
    logic  accept, q_full, q_valid, q_pop;

    assign o_in_stall  = q_full;
    assign accept      = i_in_valid && !q_full;
    assign o_cfg_ready = 1'b1;

    clns_front #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (accept),
        .i_operation     (i_operation),
        .i_target_row    (i_target_row),
        .i_target_column (i_target_column),
        .i_character     (i_character),
        .i_cfg_we        (i_cfg_valid && o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_cmd           (front_cmd)
    );

    clns_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_data  (front_cmd),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_cmd)
    );

    clns_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_cmd),
        .o_pop       (q_pop),
        .o_valid     (o_out_valid),
        .i_stall     (i_out_stall),
        .o_xfer      (xfer)
    );

    assign o_reg_select     = xfer.rs;
    assign o_nibble         = xfer.nib;
    assign o_wait_before_us = xfer.lead;
    assign o_wait_after_us  = xfer.after;
    assign o_last           = xfer.last;

endmodule

FILE: src/clns_front.sv
`timescale 1ns / 1ps
module clns_front
    import clns_pkg::*;
#(
    parameter int COLUMNS = COLUMNS_DEF,
    parameter int ROWS    = ROWS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [1:0]       i_operation,
    input  logic [7:0]       i_target_row,
    input  logic [7:0]       i_target_column,
    input  logic [7:0]       i_character,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_index,
    input  logic [ADDR_W-1:0] i_cfg_data,
    output t_cmd             o_cmd
);

    localparam int COL_W = $clog2(COLUMNS);

    logic [ADDR_W-1:0] r_base [4];
    logic [ROW_W-1:0]  r_row, n_row;
    logic [COL_W-1:0]  r_col, n_col;

    logic [7:0]        row_c, row_m1, col_c;
    logic [ROW_W-1:0]  set_row, wrap_row, addr_row;
    logic [COL_W-1:0]  set_col, addr_col;
    logic [ADDR_W-1:0] addr;
    logic              wrap;

    always_comb begin
        if (i_target_row == 8'd0) begin
            row_c = 8'd1;
        end else if (i_target_row > 8'(ROWS)) begin
            row_c = 8'(ROWS);
        end else begin
            row_c = i_target_row;
        end
        row_m1  = row_c - 8'd1;
        set_row = row_m1[ROW_W-1:0];
        col_c   = (i_target_column > 8'(COLUMNS - 1)) ? 8'(COLUMNS - 1) : i_target_column;
        set_col = col_c[COL_W-1:0];

        wrap     = (r_col == COL_W'(COLUMNS - 1));
        wrap_row = (r_row == ROW_W'(ROWS - 1)) ? '0 : r_row + 1'b1;

        addr_row = (i_operation == OP_SETCUR) ? set_row : wrap_row;
        addr_col = (i_operation == OP_SETCUR) ? set_col : '0;
        addr     = r_base[addr_row] + ADDR_W'(addr_col);

        n_row        = r_row;
        n_col        = r_col;
        o_cmd.kind   = K_CMD;
        o_cmd.byte_a = CMD_CLEAR;
        o_cmd.byte_b = CMD_SET_ADDR | {1'b0, addr};
        case (i_operation)
            OP_INIT: begin
                o_cmd.kind = K_INIT;
                n_row      = '0;
                n_col      = '0;
            end
            OP_CLEAR: begin
                n_row = '0;
                n_col = '0;
            end
            OP_SETCUR: begin
                o_cmd.byte_a = CMD_SET_ADDR | {1'b0, addr};
                n_row        = set_row;
                n_col        = set_col;
            end
            default: begin
                o_cmd.kind   = wrap ? K_DATA_ADDR : K_DATA;
                o_cmd.byte_a = i_character;
                if (wrap) begin
                    n_row = wrap_row;
                    n_col = '0;
                end else begin
                    n_col = r_col + 1'b1;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row     <= '0;
            r_col     <= '0;
            r_base[0] <= ROW0_RST;
            r_base[1] <= ROW1_RST;
            r_base[2] <= ROW2_RST;
            r_base[3] <= ROW3_RST;
        end else begin
            if (i_accept) begin
                r_row <= n_row;
                r_col <= n_col;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_ROW0: r_base[0] <= i_cfg_data;
                    CFG_ROW1: r_base[1] <= i_cfg_data;
                    CFG_ROW2: r_base[2] <= i_cfg_data;
                    CFG_ROW3: r_base[3] <= i_cfg_data;
                    default:  r_base[0] <= r_base[0];
                endcase
            end
        end
    end

endmodule

FILE: src/clns_fifo.sv
`timescale 1ns / 1ps
module clns_fifo
    import clns_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_data,
    input  logic i_pop,
    output logic o_full,
    output logic o_valid,
    output t_cmd o_data
);

    localparam int AW = $clog2(DEPTH);

    t_cmd        r_mem [DEPTH];
    logic [AW:0] r_wr, r_rd;
    logic [AW:0] fill;

    assign fill    = r_wr - r_rd;
    assign o_full  = (fill == (AW + 1)'(DEPTH));
    assign o_valid = (fill != '0);
    assign o_data  = r_mem[r_rd[AW-1:0]];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr[AW-1:0]] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
        end
    end

endmodule

FILE: src/clns_back.sv
`timescale 1ns / 1ps
module clns_back
    import clns_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_cmd_valid,
    input  t_cmd  i_cmd,
    output logic  o_pop,
    output logic  o_valid,
    input  logic  i_stall,
    output t_xfer o_xfer
);

    logic [STEP_W-1:0] r_step;
    logic              r_valid;
    t_xfer             r_xfer;
    t_xfer             x;
    logic              load;
    logic              use_b;
    logic [7:0]        b;

    always_comb begin
        use_b = r_step[1];
        b     = use_b ? i_cmd.byte_b : i_cmd.byte_a;
        if (i_cmd.kind == K_INIT) begin
            x = init_xfer(r_step);
        end else begin
            x.rs     = (i_cmd.kind != K_CMD) && !use_b;
            x.nib    = r_step[0] ? b[3:0] : b[7:4];
            x.lead   = '0;
            x.after  = WAIT_STD;
            if (r_step[0] && !x.rs && (b == CMD_CLEAR || b == CMD_HOME)) begin
                x.after = WAIT_LONG;
            end
            x.last = (i_cmd.kind == K_DATA_ADDR) ? (r_step == STEP_W'(3))
                                                 : (r_step == STEP_W'(1));
        end
    end

    assign load    = i_cmd_valid && (!r_valid || !i_stall);
    assign o_pop   = load && x.last;
    assign o_valid = r_valid;
    assign o_xfer  = r_xfer;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_xfer <= x;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_step  <= '0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_step  <= x.last ? '0 : r_step + 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

endmodule

FILE: src/clns_checker.sv
`timescale 1ns / 1ps
module clns_checker
    import clns_pkg::*;
(
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            o_out_valid,
    input logic            i_out_stall,
    input logic            o_reg_select,
    input logic [3:0]      o_nibble,
    input logic [WB_W-1:0] o_wait_before_us,
    input logic [WA_W-1:0] o_wait_after_us,
    input logic            o_last
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_nibble)
            && $stable(o_reg_select) && $stable(o_last))
        else $error("stalled transaction changed");

    a_powerup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_wait_before_us != '0 |-> o_nibble == 4'h3 && !o_reg_select
            && o_wait_after_us == WAIT_INIT0 && !o_last)
        else $error("power-up wait on wrong nibble");

    a_data_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_reg_select |-> o_wait_after_us == WAIT_STD
            && o_wait_before_us == '0)
        else $error("data nibble with command wait");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind char_lcd_nibble_sequencer clns_checker u_clns_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_out_valid      (o_out_valid),
    .i_out_stall      (i_out_stall),
    .o_reg_select     (o_reg_select),
    .o_nibble         (o_nibble),
    .o_wait_before_us (o_wait_before_us),
    .o_wait_after_us  (o_wait_after_us),
    .o_last           (o_last)
);
